>>> design/isotp_rx_pkg.sv
// Shared types and constants for the ISO-TP receive reassembly core.
// Used by the front, queue, back and top-level modules; depends on nothing.
package isotp_rx_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 12;
    localparam int TICK_W    = 16;
    localparam int SEQ_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int JOB_BYTES = 7;
    localparam int NB_W      = 3;
    localparam int QDEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_REQ_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_ID_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_ID_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    localparam logic [ID_W-1:0] PHYS_ID_BASE = 29'h700;
    localparam logic [ID_W-1:0] FLOW_ID_OFFS = 29'd8;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_FLOW    = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_SEQ_ERR = 3'd3,
        KIND_TIMEOUT = 3'd4
    } t_kind;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [NB_W-1:0]           nbytes;
        logic [LEN_W-1:0]          base;
        logic                      has_trl;
        t_kind                     trl_kind;
        logic [LEN_W-1:0]          trl_len;
        logic [ID_W-1:0]           trl_peer;
    } t_job;

endpackage

>>> design/isotp_receive_reassembly_core.sv
// Top level of the ISO-TP receive reassembly core: front end, job queue and
// result sequencer. Depends on isotp_rx_pkg, isotp_rx_front, isotp_rx_queue, isotp_rx_back.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_mode, i_frame_id, i_frame_length, i_byte0..7
//   result    out        o_valid / i_ready    o_kind, o_data_byte, o_byte_offset,
//                                             o_message_length, o_peer_id, o_last
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A transaction is classified in the cycle it is accepted and, if it yields results, queued as one job.
// The sequencer sends one result per cycle while i_ready allows, so a transaction with k
// results (up to 8) holds it for k results; transactions without results queue no job.
// The two-entry queue lets the input side run ahead while results are stalled.
// Reset is synchronous and there is no clearing pass.
module isotp_receive_reassembly_core #(
    parameter int MAX_MESSAGE_BYTES = 255
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [isotp_rx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isotp_rx_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_mode,
    input  logic [isotp_rx_pkg::ID_W-1:0]      i_frame_id,
    input  logic [3:0]                         i_frame_length,
    input  logic [7:0]                         i_byte0,
    input  logic [7:0]                         i_byte1,
    input  logic [7:0]                         i_byte2,
    input  logic [7:0]                         i_byte3,
    input  logic [7:0]                         i_byte4,
    input  logic [7:0]                         i_byte5,
    input  logic [7:0]                         i_byte6,
    input  logic [7:0]                         i_byte7,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_kind,
    output logic [7:0]                         o_data_byte,
    output logic [isotp_rx_pkg::LEN_W-1:0]     o_byte_offset,
    output logic [isotp_rx_pkg::LEN_W-1:0]     o_message_length,
    output logic [isotp_rx_pkg::ID_W-1:0]      o_peer_id,
    output logic                               o_last
);
    import isotp_rx_pkg::*;

    logic [7:0][7:0] bytes;
    logic            q_full, q_push, q_valid, q_pop;
    t_job            push_job, head_job;

    assign bytes = {i_byte7, i_byte6, i_byte5, i_byte4, i_byte3, i_byte2, i_byte1, i_byte0};

    isotp_rx_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_frame_id    (i_frame_id),
        .i_frame_length(i_frame_length),
        .i_bytes       (bytes),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    isotp_rx_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_job  (head_job)
    );

    isotp_rx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_job           (head_job),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_byte_offset   (o_byte_offset),
        .o_message_length(o_message_length),
        .o_peer_id       (o_peer_id),
        .o_last          (o_last)
    );

    a_start_no_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_mode == MODE_START)) |-> !q_push)
        else $error("start transaction produced a job");

    a_job_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && (head_job.nbytes == '0)) |-> head_job.has_trl)
        else $error("queued job carries no results");

    a_trailer_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && head_job.has_trl) |-> (head_job.trl_kind != KIND_DATA))
        else $error("trailer of queued job has payload kind");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind != KIND_DATA)) |-> o_last)
        else $error("status result not marked last");

endmodule

>>> design/isotp_rx_front.sv
// Front end: configuration registers, identifier filter, frame classification
// and reception state. Emits one job per transaction that yields results.
// Depends on isotp_rx_pkg.
module isotp_rx_front #(
    parameter int MAX_MESSAGE_BYTES = 255
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [isotp_rx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [isotp_rx_pkg::ID_W-1:0]        i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_mode,
    input  logic [isotp_rx_pkg::ID_W-1:0]        i_frame_id,
    input  logic [3:0]                           i_frame_length,
    input  logic [7:0][7:0]                      i_bytes,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output isotp_rx_pkg::t_job                   o_job
);
    import isotp_rx_pkg::*;

    logic [ID_W-1:0]   r_func_id, r_resp_min, r_resp_max, r_req_id;
    logic [TICK_W-1:0] r_timeout;

    logic              r_active, n_active;
    logic              r_ff_seen, n_ff_seen;
    logic [LEN_W-1:0]  r_total, n_total;
    logic [LEN_W-1:0]  r_rcvd, n_rcvd;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [ID_W-1:0]   r_resp_id, n_resp_id;

    logic              accept;
    logic              functional;
    logic              id_ok;
    logic [3:0]        pci_type;
    logic [3:0]        nib;
    logic [LEN_W-1:0]  ff_len;
    logic [LEN_W-1:0]  rem;
    logic [NB_W-1:0]   chunk;
    logic [LEN_W-1:0]  rcvd_sum;
    logic [TICK_W-1:0] tick_inc;
    t_job              job;

    assign o_ready    = !i_q_full;
    assign accept     = i_valid && o_ready;
    assign functional = (r_req_id == r_func_id);
    assign pci_type   = i_bytes[0][7:4];
    assign nib        = i_bytes[0][3:0];
    assign ff_len     = {nib, i_bytes[1]};
    assign rem        = (r_total > r_rcvd) ? (r_total - r_rcvd) : '0;
    assign chunk      = (rem < LEN_W'(JOB_BYTES)) ? rem[NB_W-1:0] : NB_W'(JOB_BYTES);
    assign rcvd_sum   = r_rcvd + LEN_W'(chunk);
    assign tick_inc   = (r_elapsed != '1) ? (r_elapsed + TICK_W'(1)) : r_elapsed;

    always_comb begin
        if (functional) begin
            id_ok = (i_frame_id >= r_resp_min) && (i_frame_id <= r_resp_max);
        end else begin
            id_ok = (i_frame_id[ID_W-1:11] == '0) && (i_frame_id[10:8] == 3'b111)
                    && (i_frame_id != r_req_id);
        end
    end

    always_comb begin
        n_active  = r_active;
        n_ff_seen = r_ff_seen;
        n_total   = r_total;
        n_rcvd    = r_rcvd;
        n_seq     = r_seq;
        n_elapsed = r_elapsed;
        n_resp_id = r_resp_id;
        job       = '0;
        unique case (i_mode)
            MODE_START: begin
                n_active  = 1'b1;
                n_ff_seen = 1'b0;
                n_total   = '0;
                n_rcvd    = '0;
                n_seq     = SEQ_W'(1);
                n_elapsed = '0;
                n_resp_id = '0;
            end
            MODE_TICK: begin
                if (r_active) begin
                    n_elapsed = tick_inc;
                    if (tick_inc >= r_timeout) begin
                        n_active     = 1'b0;
                        job.has_trl  = 1'b1;
                        job.trl_kind = KIND_TIMEOUT;
                    end
                end
            end
            MODE_FRAME: begin
                if (r_active && (i_frame_length != '0) && id_ok) begin
                    if (pci_type == PCI_SINGLE) begin
                        if ((nib >= 4'd1) && (nib <= 4'd7)) begin
                            for (int k = 0; k < JOB_BYTES; k++) begin
                                job.data[k] = i_bytes[k+1];
                            end
                            job.nbytes   = nib[NB_W-1:0];
                            job.has_trl  = 1'b1;
                            job.trl_kind = KIND_DONE;
                            job.trl_len  = LEN_W'(nib);
                            job.trl_peer = i_frame_id;
                            n_active     = 1'b0;
                        end
                    end else if (pci_type == PCI_FIRST) begin
                        if ((ff_len >= LEN_W'(7)) && (ff_len <= LEN_W'(MAX_MESSAGE_BYTES))) begin
                            n_total   = ff_len;
                            n_rcvd    = LEN_W'(6);
                            n_ff_seen = 1'b1;
                            n_seq     = SEQ_W'(1);
                            n_resp_id = i_frame_id;
                            for (int k = 0; k < JOB_BYTES - 1; k++) begin
                                job.data[k] = i_bytes[k+2];
                            end
                            job.nbytes   = NB_W'(6);
                            job.has_trl  = 1'b1;
                            job.trl_kind = KIND_FLOW;
                            job.trl_peer = functional ? (i_frame_id - FLOW_ID_OFFS) : r_req_id;
                        end
                    end else if ((pci_type == PCI_CONSECUTIVE) && r_ff_seen) begin
                        if (nib != r_seq) begin
                            n_active     = 1'b0;
                            job.has_trl  = 1'b1;
                            job.trl_kind = KIND_SEQ_ERR;
                        end else begin
                            for (int k = 0; k < JOB_BYTES; k++) begin
                                job.data[k] = i_bytes[k+1];
                            end
                            job.nbytes = chunk;
                            job.base   = r_rcvd;
                            n_rcvd     = rcvd_sum;
                            n_seq      = r_seq + SEQ_W'(1);
                            if (rcvd_sum >= r_total) begin
                                job.has_trl  = 1'b1;
                                job.trl_kind = KIND_DONE;
                                job.trl_len  = r_total;
                                job.trl_peer = r_resp_id;
                                n_active     = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_job  = job;
    assign o_push = accept && ((job.nbytes != '0) || job.has_trl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_id  <= ID_W'(2015);
            r_resp_min <= ID_W'(2024);
            r_resp_max <= ID_W'(2031);
            r_req_id   <= ID_W'(2015);
            r_timeout  <= TICK_W'(1000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FUNC_REQ_ID: r_func_id  <= i_cfg_data;
                CFG_RESP_ID_MIN: r_resp_min <= i_cfg_data;
                CFG_RESP_ID_MAX: r_resp_max <= i_cfg_data;
                CFG_REQUEST_ID:  r_req_id   <= i_cfg_data;
                CFG_TIMEOUT:     r_timeout  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_ff_seen <= 1'b0;
            r_total   <= '0;
            r_rcvd    <= '0;
            r_seq     <= SEQ_W'(1);
            r_elapsed <= '0;
            r_resp_id <= '0;
        end else if (accept) begin
            r_active  <= n_active;
            r_ff_seen <= n_ff_seen;
            r_total   <= n_total;
            r_rcvd    <= n_rcvd;
            r_seq     <= n_seq;
            r_elapsed <= n_elapsed;
            r_resp_id <= n_resp_id;
        end
    end

endmodule

>>> design/isotp_rx_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on isotp_rx_pkg.
module isotp_rx_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  isotp_rx_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output isotp_rx_pkg::t_job o_job
);
    import isotp_rx_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_job             r_slots [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

>>> design/isotp_rx_back.sv
// Result sequencer: expands one queued job into payload-byte results and, if present, a
// trailing result, one per cycle while i_ready allows, into a registered output stage.
// Depends on isotp_rx_pkg.
module isotp_rx_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  isotp_rx_pkg::t_job                i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_kind,
    output logic [7:0]                        o_data_byte,
    output logic [isotp_rx_pkg::LEN_W-1:0]    o_byte_offset,
    output logic [isotp_rx_pkg::LEN_W-1:0]    o_message_length,
    output logic [isotp_rx_pkg::ID_W-1:0]     o_peer_id,
    output logic                              o_last
);
    import isotp_rx_pkg::*;

    logic [NB_W-1:0]  r_idx, n_idx;
    logic             r_valid;
    t_kind            r_kind;
    logic [7:0]       r_data;
    logic [LEN_W-1:0] r_offset, r_len;
    logic [ID_W-1:0]  r_peer;
    logic             r_last;

    logic             load;
    logic             cur_is_byte;
    logic             cur_last;

    assign load        = i_q_valid && (!r_valid || i_ready);
    assign cur_is_byte = (r_idx < i_job.nbytes);
    assign cur_last    = cur_is_byte
                         ? ((r_idx == (i_job.nbytes - NB_W'(1))) && !i_job.has_trl)
                         : 1'b1;
    assign o_pop       = load && cur_last;
    assign n_idx       = cur_last ? '0 : (r_idx + NB_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= cur_last;
            if (cur_is_byte) begin
                r_kind   <= KIND_DATA;
                r_data   <= i_job.data[r_idx];
                r_offset <= i_job.base + LEN_W'(r_idx);
                r_len    <= '0;
                r_peer   <= '0;
            end else begin
                r_kind   <= i_job.trl_kind;
                r_data   <= '0;
                r_offset <= '0;
                r_len    <= i_job.trl_len;
                r_peer   <= i_job.trl_peer;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_byte_offset    = r_offset;
    assign o_message_length = r_len;
    assign o_peer_id        = r_peer;
    assign o_last           = r_last;

endmodule
